>>> rtl/mtks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtks_pkg
// Shared types, constants and defaults for the markup tag and keyword scanner.
// ----------------------------------------------------------------------------
package mtks_pkg;

    localparam int DEF_PATTERN_CHARS = 8;
    localparam int DEF_POSITION_BITS = 32;
    localparam int DEF_DEPTH_BITS    = 8;

    localparam logic [7:0] CH_OPEN  = 8'h3C;   // '<'
    localparam logic [7:0] CH_CLOSE = 8'h3E;   // '>'

    localparam logic [3:0] COUNT_MAX      = 4'd15;
    localparam logic [3:0] SCRIPT_LEN     = 4'd6;
    localparam logic [3:0] END_SCRIPT_LEN = 4'd7;

    // "script" and "/script", first character at index zero
    localparam logic [7:0] WORD_SCRIPT [6] = '{8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};
    localparam logic [7:0] WORD_END_SCRIPT [7] =
        '{8'h2F, 8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};

    typedef enum logic [1:0] {
        CFG_TAG_PATTERN     = 2'd0,
        CFG_TAG_LENGTH      = 2'd1,
        CFG_KEYWORD_PATTERN = 2'd2,
        CFG_KEYWORD_LENGTH  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [63:0] tag_pattern;
        logic [3:0]  tag_length;
        logic [63:0] keyword_pattern;
        logic [3:0]  keyword_length;
    } t_cfg;

    typedef struct packed {
        logic        tag_hit;
        logic [31:0] tag_pos;
        logic        keyword_hit;
        logic [31:0] keyword_tag_pos;
        logic        keyword_orphan;
    } t_result;

endpackage

>>> rtl/mtks_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtks_cfg
// Configuration registers: search tag and text keyword with their lengths.
// ----------------------------------------------------------------------------
module mtks_cfg
    import mtks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  logic [1:0]  i_index,
    input  logic [63:0] i_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tag_pattern     <= '0;
            r_cfg.tag_length      <= 4'd1;
            r_cfg.keyword_pattern <= '0;
            r_cfg.keyword_length  <= '0;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_index))
                CFG_TAG_PATTERN:     r_cfg.tag_pattern     <= i_data;
                CFG_TAG_LENGTH:      r_cfg.tag_length      <= i_data[3:0];
                CFG_KEYWORD_PATTERN: r_cfg.keyword_pattern <= i_data;
                CFG_KEYWORD_LENGTH:  r_cfg.keyword_length  <= i_data[3:0];
                default:             r_cfg.tag_length      <= r_cfg.tag_length;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/mtks_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtks_core
// Per-document scan state and the single-pass update for one byte.
// ----------------------------------------------------------------------------
module mtks_core
    import mtks_pkg::*;
#(
    parameter int PATTERN_CHARS = DEF_PATTERN_CHARS,
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    parameter int DEPTH_BITS    = DEF_DEPTH_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_ch,
    input  logic        i_first,
    input  t_cfg        i_cfg,
    output t_result     o_result
);

    localparam logic [3:0] PAT_CHARS = 4'(PATTERN_CHARS);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam int EXT_W = POSITION_BITS + 32;

    typedef struct packed {
        logic [POSITION_BITS-1:0] position;
        logic [DEPTH_BITS-1:0]    depth;
        logic [3:0]               tag_cnt;
        logic                     tag_mis;
        logic [1:0]               scr_mis;
        logic                     in_script;
        logic [3:0]               text_cnt;
        logic                     text_mis;
        logic [POSITION_BITS-1:0] last_tag_pos;
        logic                     have_tag;
    } t_doc_state;

    function automatic logic pat_char_is(logic [63:0] pat, logic [3:0] len,
                                         logic [3:0] idx, logic [7:0] c);
        return (idx < PAT_CHARS) && (idx < len) && (pat[{idx[2:0], 3'b000} +: 8] == c);
    endfunction

    function automatic logic full_match(logic [3:0] cnt, logic mis, logic [3:0] len);
        return !mis && (len != 4'd0) && (len <= PAT_CHARS) && (cnt == len);
    endfunction

    t_doc_state r_st;
    t_doc_state n_st;
    t_doc_state cur;
    logic       t_hit;
    logic       k_hit;
    logic [EXT_W-1:0] here_ext;
    logic [EXT_W-1:0] last_ext;

    always_comb begin
        cur   = i_first ? '0 : r_st;
        n_st  = cur;
        t_hit = 1'b0;
        k_hit = 1'b0;
        priority if (i_ch == CH_OPEN) begin
            if (cur.depth != DEPTH_MAX) n_st.depth = cur.depth + 1'b1;
            n_st.text_cnt = '0;
            n_st.text_mis = 1'b0;
        end else if (i_ch == CH_CLOSE) begin
            n_st.tag_cnt = '0;
            n_st.tag_mis = 1'b0;
            n_st.scr_mis = '0;
            if (cur.depth != '0) n_st.depth = cur.depth - 1'b1;
        end else if (cur.depth != '0) begin
            // inside a tag
            if (!((cur.tag_cnt < SCRIPT_LEN) && (WORD_SCRIPT[cur.tag_cnt[2:0]] == i_ch)))
                n_st.scr_mis[0] = 1'b1;
            if (!((cur.tag_cnt < END_SCRIPT_LEN) &&
                  (WORD_END_SCRIPT[cur.tag_cnt[2:0]] == i_ch)))
                n_st.scr_mis[1] = 1'b1;
            if (!pat_char_is(i_cfg.tag_pattern, i_cfg.tag_length, cur.tag_cnt, i_ch))
                n_st.tag_mis = 1'b1;
            if (cur.tag_cnt != COUNT_MAX) n_st.tag_cnt = cur.tag_cnt + 1'b1;
            if ((n_st.tag_cnt == SCRIPT_LEN && !n_st.scr_mis[0]) ||
                (n_st.tag_cnt == END_SCRIPT_LEN && !n_st.scr_mis[1]))
                n_st.in_script = !cur.in_script;
            if (full_match(n_st.tag_cnt, n_st.tag_mis, i_cfg.tag_length)) begin
                t_hit             = 1'b1;
                n_st.last_tag_pos = cur.position;
                n_st.have_tag     = 1'b1;
            end
        end else if (!cur.in_script && i_cfg.keyword_length != 4'd0) begin
            // plain text outside skip mode
            if (!pat_char_is(i_cfg.keyword_pattern, i_cfg.keyword_length,
                             cur.text_cnt, i_ch))
                n_st.text_mis = 1'b1;
            if (cur.text_cnt != COUNT_MAX) n_st.text_cnt = cur.text_cnt + 1'b1;
            k_hit = full_match(n_st.text_cnt, n_st.text_mis, i_cfg.keyword_length);
        end
        n_st.position = cur.position + 1'b1;
    end

    assign here_ext = {32'b0, cur.position};
    assign last_ext = {32'b0, cur.last_tag_pos};

    always_comb begin
        o_result.tag_hit         = t_hit;
        o_result.tag_pos         = here_ext[31:0];
        o_result.keyword_hit     = k_hit;
        o_result.keyword_tag_pos = (k_hit && cur.have_tag) ? last_ext[31:0] : 32'd0;
        o_result.keyword_orphan  = k_hit && !cur.have_tag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

endmodule

>>> rtl/markup_tag_keyword_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_tag_keyword_scanner
// Scans a markup byte stream, reporting tag-name and text keyword matches.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       sink       i_in_valid / o_in_ready  i_ch, i_first
//  out      source     o_out_valid / i_out_ready tag and keyword results
//  cfg      sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  one item per cycle sustained while output is not stalled; path to result
//  (input register, then the scan state update into the result register)
//  the scan state advances when an item moves from input to result register
//  reset is synchronous, active low; clears state, lengths to their defaults
//  a stalled output holds its item; the input register keeps taking items
//  until both stages are full
// ----------------------------------------------------------------------------
module markup_tag_keyword_scanner
    import mtks_pkg::*;
#(
    parameter int PATTERN_CHARS = DEF_PATTERN_CHARS,
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    parameter int DEPTH_BITS    = DEF_DEPTH_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_first,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_tag_hit,
    output logic [31:0] o_tag_pos,
    output logic        o_keyword_hit,
    output logic [31:0] o_keyword_tag_pos,
    output logic        o_keyword_orphan,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_first;
    logic       r_out_valid;
    t_result    r_res;
    t_result    n_res;
    t_cfg       cfg;
    logic       advance;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;

    mtks_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    mtks_core #(
        .PATTERN_CHARS (PATTERN_CHARS),
        .POSITION_BITS (POSITION_BITS),
        .DEPTH_BITS    (DEPTH_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_ch     (r_ch),
        .i_first  (r_first),
        .i_cfg    (cfg),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_ch    <= i_ch;
            r_first <= i_first;
        end
        if (advance) r_res <= n_res;
    end

    assign o_out_valid       = r_out_valid;
    assign o_tag_hit         = r_res.tag_hit;
    assign o_tag_pos         = r_res.tag_pos;
    assign o_keyword_hit     = r_res.keyword_hit;
    assign o_keyword_tag_pos = r_res.keyword_tag_pos;
    assign o_keyword_orphan  = r_res.keyword_orphan;

`ifndef SYNTH
    a_orphan_has_no_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_keyword_orphan) |-> (o_keyword_hit && o_keyword_tag_pos == 32'd0))
        else $error("orphan keyword item carries a tag position");

    a_hits_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_tag_hit && o_keyword_hit))
        else $error("tag and keyword hit on the same byte");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room in the pipeline");

    a_first_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_first) |=> (o_out_valid && o_tag_pos == 32'd0))
        else $error("first byte of a document not at position zero");
`endif

endmodule
